@@ src/gdad_pkg.sv @@
// Shared types, constants and calendar helpers for the date-plus-days block.
`timescale 1ns / 1ps
package gdad_pkg;

	// Field widths.
	localparam int YEAR_IN_W  = 14;
	localparam int YEAR_OUT_W = 15;
	localparam int MONTH_W    = 4;
	localparam int DAY_W      = 5;
	localparam int ADD_W      = 14;

	// Running day count: day + add + a whole leap year stays below 2**15.
	localparam int REM_W = 15;

	// Year modulo 400 fits in nine bits.
	localparam int MOD_W = 9;

	// Restoring reduction of the year by 400 << k, k from MOD_TOP down to 0.
	localparam logic [REM_W-1:0] MOD_BASE = 15'd400;
	localparam int               K_W      = 3;
	localparam logic [K_W-1:0]   MOD_TOP  = 3'd5;

	// Last remainder value before the modulo-400 counter wraps.
	localparam logic [MOD_W-1:0] MOD_LAST = 9'd399;

	// Month numbers that bound the walk.
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef logic [DAY_W-1:0] mlen_t;

	// Month lengths in a common year, January first.
	localparam mlen_t MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Operation of the shared arithmetic unit.
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// Result and flags of the shared arithmetic unit.
	typedef struct packed {
		logic [REM_W-1:0] res;
		logic             ge;
		logic             gt;
	} alu_res_t;

	// Leap rule from the year modulo 400; 400 is a multiple of 4 and 100.
	function automatic logic is_leap(input logic [MOD_W-1:0] r);
		logic cent;
		cent = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
		return (r == '0) || ((r[1:0] == 2'b00) && !cent);
	endfunction

	// Length of a month; numbers outside 1 to 12 have length zero.
	function automatic mlen_t month_days(input logic leap, input logic [MONTH_W-1:0] m);
		mlen_t len;
		if (m < MONTH_JAN || m > MONTH_DEC) begin
			len = '0;
		end else if (m == MONTH_FEB) begin
			len = leap ? 5'd29 : 5'd28;
		end else begin
			len = MONTH_LEN[m - MONTH_JAN];
		end
		return len;
	endfunction

endpackage

@@ src/gdad_if.sv @@
// Handshake channels for the date request and the date result.
`timescale 1ns / 1ps
interface gdad_req_if;
	logic                           valid;
	logic                           ready;
	logic [gdad_pkg::YEAR_IN_W-1:0] start_year;
	logic [gdad_pkg::MONTH_W-1:0]   start_month;
	logic [gdad_pkg::DAY_W-1:0]     start_day;
	logic [gdad_pkg::ADD_W-1:0]     days_to_add;

	modport source (output valid, start_year, start_month, start_day, days_to_add,
		input ready);
	modport sink (input valid, start_year, start_month, start_day, days_to_add,
		output ready);
endinterface

interface gdad_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [gdad_pkg::YEAR_OUT_W-1:0] result_year;
	logic [gdad_pkg::MONTH_W-1:0]    result_month;
	logic [gdad_pkg::DAY_W-1:0]      result_day;

	modport source (output valid, result_year, result_month, result_day, input ready);
	modport sink (input valid, result_year, result_month, result_day, output ready);
endinterface

@@ src/gdad_alu.sv @@
// Shared add, subtract and compare unit used by the reduction, summing and walk steps of the sequencer.
`timescale 1ns / 1ps
module gdad_alu (
	input  gdad_pkg::alu_op_t            op,
	input  logic [gdad_pkg::REM_W-1:0]   a,
	input  logic [gdad_pkg::REM_W-1:0]   b,
	output gdad_pkg::alu_res_t           y
);
	import gdad_pkg::*;

	logic [REM_W:0] diff;
	logic [REM_W:0] sum;

	// One subtractor gives both the difference and the compare flags.
	assign diff = {1'b0, a} - {1'b0, b};
	assign sum  = {1'b0, a} + {1'b0, b};

	always_comb begin
		y.ge  = !diff[REM_W];
		y.gt  = !diff[REM_W] && (a != b);
		y.res = (op == ALU_ADD) ? sum[REM_W-1:0] : diff[REM_W-1:0];
	end

endmodule

@@ src/gregorian_date_add_days.sv @@
// Top level: adds a day count to a Gregorian date with a small sequencer.
// Steps: take the word, reduce the year modulo 400, add the months before the start
// month, then walk one month per step until the day fits in the month.
// Throughput: one word at a time; a new word is taken once the previous result
// sits in the output register, which loads only while it is empty or being read.
// Reset: arst_n clears the sequencer and the output valid flag at once.
`timescale 1ns / 1ps
module gregorian_date_add_days (
	input  logic        clk,
	input  logic        arst_n,
	gdad_req_if.sink    req,
	gdad_rsp_if.source  rsp
);
	import gdad_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_SUM  = 2'd2;
	localparam logic [1:0] ST_WALK = 2'd3;

	logic [1:0]            state_q;
	logic [K_W-1:0]        k_q;
	logic [REM_W-1:0]      mod_q;
	logic [YEAR_OUT_W-1:0] year_q;
	logic [MONTH_W-1:0]    m_q;
	logic [MONTH_W-1:0]    month_lim_q;
	logic [REM_W-1:0]      rem_q;

	logic                  out_valid_q;
	logic [YEAR_OUT_W-1:0] out_year_q;
	logic [MONTH_W-1:0]    out_month_q;
	logic [DAY_W-1:0]      out_day_q;

	alu_op_t          alu_op;
	logic [REM_W-1:0] alu_a;
	logic [REM_W-1:0] alu_b;
	alu_res_t         alu_y;
	logic             leap;
	mlen_t            len;
	logic             out_free;

	// Calendar facts for the current month of the month sum and the walk.
	assign leap     = is_leap(mod_q[MOD_W-1:0]);
	assign len      = month_days(leap, m_q);
	assign out_free = !out_valid_q || rsp.ready;

	assign req.ready = (state_q == ST_IDLE);

	// Operand selection for the shared unit.
	always_comb begin
		alu_op = ALU_SUB;
		alu_a  = rem_q;
		alu_b  = REM_W'(len);
		case (state_q)
			ST_MOD: begin
				alu_a = mod_q;
				alu_b = MOD_BASE << k_q;
			end
			ST_SUM: begin
				alu_op = ALU_ADD;
			end
			default: begin
				alu_op = ALU_SUB;
			end
		endcase
	end

	gdad_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	// Sequencer: reduce the year modulo 400, sum the leading months, then walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (k_q == '0) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (m_q >= month_lim_q) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!alu_y.gt && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current word.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					year_q      <= YEAR_OUT_W'(req.start_year);
					mod_q       <= REM_W'(req.start_year);
					month_lim_q <= req.start_month;
					m_q         <= MONTH_JAN;
					rem_q       <= REM_W'(req.start_day) + REM_W'(req.days_to_add);
					k_q         <= MOD_TOP;
				end
			end
			ST_MOD: begin
				if (alu_y.ge) begin
					mod_q <= alu_y.res;
				end
				k_q <= k_q - 1'b1;
			end
			ST_SUM: begin
				if (m_q < month_lim_q) begin
					rem_q <= alu_y.res;
					m_q   <= m_q + 1'b1;
				end else begin
					m_q <= MONTH_JAN;
				end
			end
			ST_WALK: begin
				if (alu_y.gt) begin
					rem_q <= alu_y.res;
					if (m_q == MONTH_DEC) begin
						m_q    <= MONTH_JAN;
						year_q <= year_q + 1'b1;
						mod_q  <= (mod_q[MOD_W-1:0] == MOD_LAST) ? '0 : mod_q + 1'b1;
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	// Output register holds one result word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WALK && !alu_y.gt && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && !alu_y.gt && out_free) begin
			out_year_q  <= year_q;
			out_month_q <= m_q;
			out_day_q   <= rem_q[DAY_W-1:0];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_year  = out_year_q;
	assign rsp.result_month = out_month_q;
	assign rsp.result_day   = out_day_q;

	// An accepted word always starts with the year reduction.
	a_accept_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_MOD))
		else $error("accepted word did not start the year reduction");

	// The walk only visits real months.
	a_walk_month: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (m_q >= MONTH_JAN && m_q <= MONTH_DEC))
		else $error("walk month out of range");

	// After the reduction the remainder stays below 400 and agrees with the year in its two low bits.
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM || state_q == ST_WALK) |->
		(mod_q <= REM_W'(MOD_LAST) && mod_q[1:0] == year_q[1:0]))
		else $error("year remainder lost track of the year");

	// A new result word only comes from the end of the walk.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> ($past(state_q) == ST_WALK))
		else $error("result word raised outside the walk");

endmodule

@@ sim/tb_gregorian_date_add_days.sv @@
// Self-checking testbench for the date-plus-days block: directed table, then random words.
`timescale 1ns / 1ps
module tb_gregorian_date_add_days;
	import gdad_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RANDOM_WORDS = 1000;
	localparam int IDLE_PCT     = 23;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 700;
	localparam int STALL_LIMIT  = 5000;

	// One request word as the sender sees it.
	typedef struct packed {
		logic [YEAR_IN_W-1:0] year;
		logic [MONTH_W-1:0]   month;
		logic [DAY_W-1:0]     day;
		logic [ADD_W-1:0]     add;
	} date_word_t;

	// One result word.
	typedef struct packed {
		logic [YEAR_OUT_W-1:0] year;
		logic [MONTH_W-1:0]    month;
		logic [DAY_W-1:0]      day;
	} date_t;

	// Directed row: request, whether the answer is typed in, and the typed answer.
	typedef struct packed {
		logic [YEAR_IN_W-1:0]  yr;
		logic [MONTH_W-1:0]    mo;
		logic [DAY_W-1:0]      dy;
		logic [ADD_W-1:0]      add;
		logic                  typed;
		logic [YEAR_OUT_W-1:0] eyr;
		logic [MONTH_W-1:0]    emo;
		logic [DAY_W-1:0]      edy;
	} dir_row_t;

	localparam int DIR_ROWS = 24;

	// Plain dates, leap rules, the out-of-range months and days, and field extremes.
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{2024, 1, 1, 0, 1, 2024, 1, 1},
		'{1, 1, 1, 0, 1, 1, 1, 1},
		'{2023, 12, 31, 1, 1, 2024, 1, 1},
		'{9999, 12, 31, 1, 1, 10000, 1, 1},
		'{2024, 2, 28, 1, 1, 2024, 2, 29},
		'{2023, 2, 28, 1, 1, 2023, 3, 1},
		'{1900, 2, 28, 1, 1, 1900, 3, 1},
		'{2000, 2, 28, 1, 1, 2000, 2, 29},
		'{2400, 2, 29, 0, 1, 2400, 2, 29},
		'{0, 2, 28, 1, 1, 0, 2, 29},
		'{5, 0, 0, 0, 1, 5, 1, 0},
		'{5, 1, 0, 0, 1, 5, 1, 0},
		'{7, 0, 15, 0, 1, 7, 1, 15},
		'{2023, 13, 1, 0, 1, 2024, 1, 1},
		'{2023, 15, 31, 0, 1, 2024, 1, 31},
		'{2023, 2, 31, 0, 1, 2023, 3, 3},
		'{2023, 4, 31, 0, 1, 2023, 5, 1},
		'{2024, 2, 29, 365, 1, 2025, 2, 28},
		'{16383, 1, 1, 0, 1, 16383, 1, 1},
		'{16383, 15, 31, 16383, 0, 0, 0, 0},
		'{9999, 12, 31, 16383, 0, 0, 0, 0},
		'{0, 0, 0, 16383, 0, 0, 0, 0},
		'{1, 1, 1, 16383, 0, 0, 0, 0},
		'{12345, 7, 4, 10000, 0, 0, 0, 0}
	};

	logic clk = 1'b0;
	logic arst_n;

	gdad_req_if req_ch ();
	gdad_rsp_if rsp_ch ();

	gregorian_date_add_days dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	date_t due_dates [$];
	date_t pending_date;
	int    mismatches   = 0;
	int    results_seen = 0;
	int    stall_cycles = 0;

	always #(HALF_PERIOD) clk = ~clk;

	// Leap rule: divisible by 400, or by 4 and not by 100.
	function automatic bit is_leap_year(input int y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	// Month length; month numbers outside 1 to 12 count as empty.
	function automatic int days_of_month(input int y, input int m);
		int len;
		case (m)
			1, 3, 5, 7, 8, 10, 12: len = 31;
			4, 6, 9, 11:           len = 30;
			2:                     len = is_leap_year(y) ? 29 : 28;
			default:               len = 0;
		endcase
		return len;
	endfunction

	// Ordinal day in the starting year plus the count, then walk month by month.
	function automatic date_t date_after_days(input date_word_t w);
		int    y;
		int    m;
		int    rest;
		date_t d;
		y    = int'(w.year);
		rest = int'(w.day);
		for (m = 1; m < int'(w.month); m++) begin
			rest += days_of_month(y, m);
		end
		rest += int'(w.add);
		m = 1;
		while (rest > days_of_month(y, m)) begin
			rest -= days_of_month(y, m);
			m++;
			if (m > 12) begin
				m = 1;
				y++;
			end
		end
		d.year  = y[YEAR_OUT_W-1:0];
		d.month = m[MONTH_W-1:0];
		d.day   = rest[DAY_W-1:0];
		return d;
	endfunction

	// Random request: mostly valid dates, some near century years, some raw fields.
	function automatic date_word_t random_date_word();
		date_word_t w;
		int         y;
		int         m;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			y = $urandom_range(9999, 1);
		end else if (pick < 80) begin
			y = $urandom_range(163, 1) * 100 + $urandom_range(4) - 2;
		end else begin
			y = $urandom_range(16383);
		end
		m = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(15);
		w.year  = y[YEAR_IN_W-1:0];
		w.month = m[MONTH_W-1:0];
		if ($urandom_range(99) < 85 && days_of_month(y, m) != 0) begin
			w.day = DAY_W'($urandom_range(days_of_month(y, m), 1));
		end else begin
			w.day = DAY_W'($urandom_range(31));
		end
		pick = $urandom_range(99);
		if (pick < 50) begin
			w.add = ADD_W'($urandom_range(400));
		end else if (pick < 70) begin
			w.add = ADD_W'($urandom_range(3000));
		end else begin
			w.add = ADD_W'($urandom_range(16383));
		end
		return w;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("[%0t] mismatch in %s: got %0d, expected %0d (result %0d)",
			$realtime, what, got, want, results_seen);
		mismatches++;
	endtask

	// Offer one word, after random idle cycles unless steady, and hold it until the block takes it.
	task automatic offer_date(input date_word_t w, input date_t want, input bit steady);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.start_year  <= w.year;
		req_ch.start_month <= w.month;
		req_ch.start_day   <= w.day;
		req_ch.days_to_add <= w.add;
		pending_date       <= want;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Record each accepted word and check each accepted result against the oldest one.
	always @(posedge clk) begin
		date_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_dates.size() == 0) begin
					report("unexpected result year", int'(rsp_ch.result_year), -1);
				end else begin
					want = due_dates.pop_front();
					if (rsp_ch.result_year !== want.year)
						report("result_year", int'(rsp_ch.result_year), int'(want.year));
					if (rsp_ch.result_month !== want.month)
						report("result_month", int'(rsp_ch.result_month), int'(want.month));
					if (rsp_ch.result_day !== want.day)
						report("result_day", int'(rsp_ch.result_day), int'(want.day));
				end
				results_seen++;
			end
			if (req_ch.valid && req_ch.ready) begin
				due_dates.push_back(pending_date);
			end
		end
	end

	// Watchdog: too many cycles in a row with no word moving on either side.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL gregorian_date_add_days");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Receiver: random stalls, one long hold-off, and a window that always accepts.
	initial begin
		bit held;
		held = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && results_seen >= 100) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (results_seen >= 450 && results_seen < 600) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Sender: reset, directed table, random words, then drain and judge.
	initial begin
		date_word_t w;
		date_t      want;
		arst_n             = 1'b0;
		pending_date       = '0;
		req_ch.valid       = 1'b0;
		req_ch.start_year  = '0;
		req_ch.start_month = '0;
		req_ch.start_day   = '0;
		req_ch.days_to_add = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			w = '{DIR_TAB[i].yr, DIR_TAB[i].mo, DIR_TAB[i].dy, DIR_TAB[i].add};
			if (DIR_TAB[i].typed) begin
				want = '{DIR_TAB[i].eyr, DIR_TAB[i].emo, DIR_TAB[i].edy};
			end else begin
				want = date_after_days(w);
			end
			offer_date(w, want, 1'b0);
		end

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// After 600 random words, stop offering until the block has handed back everything.
			if (i == 600) begin
				req_ch.valid <= 1'b0;
				do @(posedge clk); while (due_dates.size() != 0);
			end
			w = random_date_word();
			offer_date(w, date_after_days(w), i >= 300 && i < 450);
		end

		req_ch.valid <= 1'b0;
		do @(posedge clk); while (due_dates.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && due_dates.size() == 0) begin
			$display("PASS gregorian_date_add_days");
		end else begin
			$display("FAIL gregorian_date_add_days");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/gdad_pkg.sv
src/gdad_if.sv
src/gdad_alu.sv
src/gregorian_date_add_days.sv
sim/tb_gregorian_date_add_days.sv
